>>> rtl/nbp_pkg.sv
// Shared types, constants and the character map of the nucleotide packer.
package nbp_pkg;

    localparam int BASES_PER_WORD = 16;
    localparam int SLOT_W         = $clog2(BASES_PER_WORD);
    localparam int CNT_W          = 32;
    localparam int MAX_RESULTS    = 3;
    localparam int NRES_W         = $clog2(MAX_RESULTS + 1);
    localparam int FIFO_DEPTH     = 4;
    localparam int PTR_W          = $clog2(FIFO_DEPTH);
    localparam int FCNT_W         = $clog2(FIFO_DEPTH + 1);

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [2:0]       CODE_HOLE = 3'd4;

    typedef enum logic [1:0] {
        KIND_WORD    = 2'd0,
        KIND_HOLE    = 2'd1,
        KIND_SUMMARY = 2'd2
    } t_kind;

    // Compact result: field a and b carry whichever values the kind needs.
    typedef struct packed {
        t_kind            kind;
        logic [CNT_W-1:0] a;
        logic [CNT_W-1:0] b;
        logic             acc;
        logic             last;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0] base_count;
        logic [CNT_W-1:0] word_acc;
        logic             in_hole;
        logic [CNT_W-1:0] run_start;
        logic [CNT_W-1:0] run_length;
        logic [CNT_W-1:0] run_count;
        logic             rejected;
    } t_state;

    function automatic logic [2:0] base_code(input logic [7:0] ch);
        logic [2:0] code;
        case (ch)
            8'h41, 8'h61: code = 3'd0;
            8'h43, 8'h63: code = 3'd1;
            8'h47, 8'h67: code = 3'd2;
            8'h54, 8'h74: code = 3'd3;
            default:      code = CODE_HOLE;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/nucleotide_2bit_packer_with_holes.sv
// Top level of the 2-bit nucleotide packer with hole-run records.
//
// Input channel (i_in_valid / o_in_ready) carries one character item a cycle,
// with i_end_of_sequence on the final character of a sequence. A, C, G, T in
// either case are packed sixteen to a 32-bit word, first base lowest; any
// other character is a hole. Each run of holes after a base gives one hole
// record; a hole before any base refuses the sequence, which then gives
// only a summary. Output channel (o_out_valid / i_out_ready) carries result
// items: packed words, hole records and, after the final character, a
// summary; the last result caused by one character carries o_final_record.
// A result is offered in the cycle after its character is accepted when no
// earlier result is still waiting in the queue.
// Throughput: one character per cycle while each causes at most one result
// and the receiver stays ready; several results of one character leave in
// turn. The limit is the single output port draining the four-entry queue.
// o_in_ready falls while the queue cannot take a worst-case batch of three
// results, so a stalled receiver back-pressures the sender once two results wait in the queue.
// Reset clears the packer state and empties the queue at once.
module nucleotide_2bit_packer_with_holes
    import nbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_base_char,
    input  logic        i_end_of_sequence,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_record_kind,
    output logic [31:0] o_packed_word,
    output logic [31:0] o_hole_position,
    output logic [31:0] o_hole_length,
    output logic [31:0] o_base_total,
    output logic [31:0] o_hole_total,
    output logic        o_accepted,
    output logic        o_final_record
);

    t_state            r_state, n_state;
    t_result           step_res [MAX_RESULTS];
    logic [NRES_W-1:0] step_n;
    logic [NRES_W-1:0] push_n;
    logic              in_accept;
    t_result           head;

    assign in_accept = i_in_valid && o_in_ready;

    // Next state and results for the offered character.
    nbp_step u_step (
        .i_state           (r_state),
        .i_base_char       (i_base_char),
        .i_end_of_sequence (i_end_of_sequence),
        .o_state           (n_state),
        .o_res             (step_res),
        .o_res_n           (step_n)
    );

    // Advance the packer only on an accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    assign push_n = in_accept ? step_n : '0;

    nbp_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_res    (step_res),
        .i_push_n (push_n),
        .o_room   (o_in_ready),
        .o_head   (head),
        .o_valid  (o_out_valid),
        .i_pop    (i_out_ready)
    );

    // Unpack the compact queue entry; fields foreign to the kind read zero.
    always_comb begin
        o_record_kind   = head.kind;
        o_packed_word   = '0;
        o_hole_position = '0;
        o_hole_length   = '0;
        o_base_total    = '0;
        o_hole_total    = '0;
        o_accepted      = head.acc;
        o_final_record  = head.last;
        case (head.kind)
            KIND_WORD: begin
                o_packed_word = head.a;
            end
            KIND_HOLE: begin
                o_hole_position = head.a;
                o_hole_length   = head.b;
            end
            KIND_SUMMARY: begin
                o_base_total = head.a;
                o_hole_total = head.b;
            end
            default: begin
                o_accepted = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/nbp_step.sv
// Per-character update: next packer state and the results one character causes.
module nbp_step
    import nbp_pkg::*;
(
    input  t_state              i_state,
    input  logic [7:0]          i_base_char,
    input  logic                i_end_of_sequence,
    output t_state              o_state,
    output t_result             o_res [MAX_RESULTS],
    output logic [NRES_W-1:0]   o_res_n
);

    logic [2:0]        code;
    t_state            s;
    logic [SLOT_W-1:0] slot;
    logic [NRES_W-1:0] n;
    t_result           res [MAX_RESULTS];

    assign code = base_code(i_base_char);
    assign slot = i_state.base_count[SLOT_W-1:0];

    always_comb begin
        s = i_state;
        n = '0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            res[i] = '0;
        end

        if (!i_state.rejected) begin
            if (code == CODE_HOLE) begin
                if (i_state.in_hole) begin
                    if (i_state.run_length != CNT_MAX) begin
                        s.run_length = i_state.run_length + 1'b1;
                    end
                end else if (i_state.base_count == '0) begin
                    s.rejected = 1'b1;
                end else begin
                    s.in_hole    = 1'b1;
                    s.run_start  = i_state.base_count - 1'b1;
                    s.run_length = CNT_W'(1);
                    if (i_state.run_count != CNT_MAX) begin
                        s.run_count = i_state.run_count + 1'b1;
                    end
                end
            end else begin
                // A base closes any open run first.
                if (i_state.in_hole) begin
                    res[0].kind = KIND_HOLE;
                    res[0].a    = i_state.run_start;
                    res[0].b    = i_state.run_length;
                    n           = NRES_W'(1);
                    s.in_hole   = 1'b0;
                end
                if (i_state.base_count != CNT_MAX) begin
                    s.word_acc   = i_state.word_acc
                                 | ({{(CNT_W-2){1'b0}}, code[1:0]} << {slot, 1'b0});
                    s.base_count = i_state.base_count + 1'b1;
                    if (s.base_count[SLOT_W-1:0] == '0) begin
                        res[n[1:0]].kind = KIND_WORD;
                        res[n[1:0]].a    = s.word_acc;
                        n                = n + 1'b1;
                        s.word_acc       = '0;
                    end
                end
            end
        end

        if (i_end_of_sequence) begin
            if (s.rejected) begin
                res[n[1:0]].kind = KIND_SUMMARY;
                n                = n + 1'b1;
            end else begin
                if (s.in_hole) begin
                    res[n[1:0]].kind = KIND_HOLE;
                    res[n[1:0]].a    = s.run_start;
                    res[n[1:0]].b    = s.run_length;
                    n                = n + 1'b1;
                end
                if (s.base_count[SLOT_W-1:0] != '0) begin
                    res[n[1:0]].kind = KIND_WORD;
                    res[n[1:0]].a    = s.word_acc;
                    n                = n + 1'b1;
                end
                res[n[1:0]].kind = KIND_SUMMARY;
                res[n[1:0]].a    = s.base_count;
                res[n[1:0]].b    = s.run_count;
                res[n[1:0]].acc  = 1'b1;
                n                = n + 1'b1;
            end
            s = '0;
        end

        for (int i = 0; i < MAX_RESULTS; i++) begin
            res[i].last = (NRES_W'(i + 1) == n);
        end
    end

    assign o_state = s;
    assign o_res   = res;
    assign o_res_n = n;

endmodule

>>> rtl/nbp_result_fifo.sv
// Result queue: takes up to three results at once, pops one per cycle on i_pop.
module nbp_result_fifo
    import nbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_result           i_res [MAX_RESULTS],
    input  logic [NRES_W-1:0] i_push_n,
    output logic              o_room,
    output t_result           o_head,
    output logic              o_valid,
    input  logic              i_pop
);

    t_result           r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [FCNT_W-1:0] r_count, n_count;
    logic              pop;

    assign pop     = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    // Room for a worst-case batch of results.
    assign o_room  = (r_count <= FCNT_W'(FIFO_DEPTH - MAX_RESULTS));

    assign n_wr_ptr = r_wr_ptr + PTR_W'(i_push_n);
    assign n_rd_ptr = r_rd_ptr + PTR_W'(pop);
    assign n_count  = r_count + FCNT_W'(i_push_n) - FCNT_W'(pop);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (NRES_W'(i) < i_push_n) begin
                r_mem[r_wr_ptr + PTR_W'(i)] <= i_res[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FCNT_W'(FIFO_DEPTH))
        else $error("result queue count beyond depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n != '0) |-> o_room)
        else $error("results pushed without room for a full batch");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_push_n != '0) && !pop) |=>
            (r_count == $past(r_count) + FCNT_W'($past(i_push_n))))
        else $error("result queue count lost a push");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with pointers apart");

endmodule

>>> tb/tb_nucleotide_2bit_packer_with_holes.sv
// Self-checking testbench for the 2-bit nucleotide packer with hole-run records.
`timescale 1ns / 100ps

module tb_nucleotide_2bit_packer_with_holes;
    import nbp_pkg::*;

    // Long receiver hold-off, no-progress limit and tail wait, all in cycles.
    localparam int unsigned LONG_HOLD   = 150;
    localparam int unsigned QUIET_LIMIT = 1000;
    localparam int unsigned TAIL_CYCLES = 10;
    localparam int unsigned RAND_ITEMS  = 174;
    localparam int unsigned N_ROWS      = 26;

    // One result item, all fields at port widths.
    typedef struct packed {
        t_kind       kind;
        logic [31:0] word;
        logic [31:0] pos;
        logic [31:0] len;
        logic [31:0] bases;
        logic [31:0] holes;
        logic        acc;
        logic        fin;
    } nuc_rec_t;

    // Packer state as the predictor keeps it.
    typedef struct packed {
        logic [31:0] bases;
        logic [31:0] acc_word;
        logic        hole_open;
        logic [31:0] run_at;
        logic [31:0] run_len;
        logic [31:0] runs;
        logic        refused;
    } packer_state_t;

    // One directed row: a character, its end flag and, where typed, the single
    // result it must cause.
    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
        logic       typed;
        nuc_rec_t   want;
    } stim_row_t;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_in_valid        = 1'b0;
    logic [7:0]  i_base_char       = 8'h00;
    logic        i_end_of_sequence = 1'b0;
    logic        i_out_ready       = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_record_kind;
    logic [31:0] o_packed_word;
    logic [31:0] o_hole_position;
    logic [31:0] o_hole_length;
    logic [31:0] o_base_total;
    logic [31:0] o_hole_total;
    logic        o_accepted;
    logic        o_final_record;

    nucleotide_2bit_packer_with_holes i_dut (.*);

    packer_state_t nuc_st = '0;
    nuc_rec_t      due_records[$];
    int unsigned   mismatch_cnt  = 0;
    int unsigned   quiet_cycles  = 0;
    int unsigned   hold_requests = 0;
    int unsigned   holds_served  = 0;
    int unsigned   rx_wait       = 0;
    int unsigned   rx_gap;
    bit            calm_phase    = 1'b0;
    string         nuc_letters   = "ACGTacgt";

    // Directed part: a sequence refused by its leading hole, an all-ones word,
    // a two-character hole run closed by a base, and a hole run still open at
    // the final character (hole record, partial word and summary together).
    stim_row_t dir_rows [N_ROWS] = '{
        '{8'h00, 1'b0, 1'b0, '0},
        '{"A",   1'b0, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b1,
          '{KIND_SUMMARY, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1}},
        '{"T", 1'b0, 1'b0, '0}, '{"t", 1'b0, 1'b0, '0}, '{"T", 1'b0, 1'b0, '0},
        '{"t", 1'b0, 1'b0, '0}, '{"T", 1'b0, 1'b0, '0}, '{"t", 1'b0, 1'b0, '0},
        '{"T", 1'b0, 1'b0, '0}, '{"t", 1'b0, 1'b0, '0}, '{"T", 1'b0, 1'b0, '0},
        '{"t", 1'b0, 1'b0, '0}, '{"T", 1'b0, 1'b0, '0}, '{"t", 1'b0, 1'b0, '0},
        '{"T", 1'b0, 1'b0, '0}, '{"t", 1'b0, 1'b0, '0}, '{"T", 1'b0, 1'b0, '0},
        '{"t", 1'b0, 1'b1,
          '{KIND_WORD, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1}},
        '{"N", 1'b0, 1'b0, '0},
        '{"n", 1'b0, 1'b0, '0},
        '{"a", 1'b0, 1'b1,
          '{KIND_HOLE, 32'd0, 32'd15, 32'd2, 32'd0, 32'd0, 1'b0, 1'b1}},
        '{"C", 1'b0, 1'b0, '0},
        '{"-", 1'b0, 1'b0, '0},
        '{"g", 1'b0, 1'b0, '0},
        '{"~", 1'b1, 1'b0, '0}
    };

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Map a character to its 2-bit code; fold case by clearing bit 5.
    function automatic logic [2:0] nuc_code(input logic [7:0] ch);
        logic [7:0] up;
        up = ch & 8'hDF;
        if (up == "A") return 3'd0;
        if (up == "C") return 3'd1;
        if (up == "G") return 3'd2;
        if (up == "T") return 3'd3;
        return CODE_HOLE;
    endfunction

    function automatic nuc_rec_t mk_rec(input t_kind kind, input logic [31:0] word,
                                        input logic [31:0] pos, input logic [31:0] len,
                                        input logic [31:0] bases,
                                        input logic [31:0] holes, input logic acc);
        return '{kind, word, pos, len, bases, holes, acc, 1'b0};
    endfunction

    // Random byte that is not a base character.
    function automatic logic [7:0] hole_byte();
        logic [7:0] ch;
        do ch = 8'($urandom_range(0, 255)); while (nuc_code(ch) != CODE_HOLE);
        return ch;
    endfunction

    // Idle length: mostly none, sometimes short, rarely long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Advance the packer state by one character and return the results it causes.
    task automatic pack_char(input logic [7:0] ch, input logic eos, output nuc_rec_t recs[$]);
        logic [2:0]  code;
        int unsigned slot;
        recs = {};
        code = nuc_code(ch);
        if (!nuc_st.refused) begin
            if (code == CODE_HOLE) begin
                if (nuc_st.hole_open) begin
                    if (nuc_st.run_len != CNT_MAX) nuc_st.run_len = nuc_st.run_len + 1;
                end else if (nuc_st.bases == 0) begin
                    // Hole before any base: refuse the whole sequence.
                    nuc_st.refused = 1'b1;
                end else begin
                    nuc_st.hole_open = 1'b1;
                    nuc_st.run_at    = nuc_st.bases - 1;
                    nuc_st.run_len   = 32'd1;
                    if (nuc_st.runs != CNT_MAX) nuc_st.runs = nuc_st.runs + 1;
                end
            end else begin
                // A base closes any open run, even when the count is saturated.
                if (nuc_st.hole_open) begin
                    recs.push_back(mk_rec(KIND_HOLE, '0, nuc_st.run_at, nuc_st.run_len,
                                          '0, '0, 1'b0));
                    nuc_st.hole_open = 1'b0;
                end
                if (nuc_st.bases != CNT_MAX) begin
                    slot = nuc_st.bases % BASES_PER_WORD;
                    nuc_st.acc_word = nuc_st.acc_word | (32'(code[1:0]) << (2 * slot));
                    nuc_st.bases = nuc_st.bases + 1;
                    if (nuc_st.bases % BASES_PER_WORD == 0) begin
                        recs.push_back(mk_rec(KIND_WORD, nuc_st.acc_word, '0, '0, '0, '0,
                                              1'b0));
                        nuc_st.acc_word = '0;
                    end
                end
            end
        end
        if (eos) begin
            if (nuc_st.refused) begin
                recs.push_back(mk_rec(KIND_SUMMARY, '0, '0, '0, '0, '0, 1'b0));
            end else begin
                if (nuc_st.hole_open)
                    recs.push_back(mk_rec(KIND_HOLE, '0, nuc_st.run_at, nuc_st.run_len,
                                          '0, '0, 1'b0));
                if (nuc_st.bases % BASES_PER_WORD != 0)
                    recs.push_back(mk_rec(KIND_WORD, nuc_st.acc_word, '0, '0, '0, '0, 1'b0));
                recs.push_back(mk_rec(KIND_SUMMARY, '0, '0, '0, nuc_st.bases, nuc_st.runs,
                                      1'b1));
            end
            nuc_st = '0;
        end
        if (recs.size() > 0) recs[recs.size() - 1].fin = 1'b1;
    endtask

    // Offer one item, wait for its acceptance, then queue what it must cause.
    // Valid drops only when a gap follows, so it never falls and rises in one step.
    task automatic send_char(input logic [7:0] ch, input logic eos, input logic typed,
                             input nuc_rec_t want);
        int unsigned gap;
        nuc_rec_t    batch[$];
        gap = calm_phase ? 0 : pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_base_char       <= ch;
        i_end_of_sequence <= eos;
        do @(posedge i_clk); while (!o_in_ready);
        pack_char(ch, eos, batch);
        if (typed) due_records.push_back(want);
        else foreach (batch[k]) due_records.push_back(batch[k]);
    endtask

    // Stop offering and hold until every queued result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (due_records.size() != 0);
    endtask

    task automatic note_mismatch(input string what, input nuc_rec_t want, input nuc_rec_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("%0t: %s", $realtime, what);
            $display("  expected kind=%0d word=%h pos=%0d len=%0d bases=%0d holes=%0d acc=%b fin=%b",
                     want.kind, want.word, want.pos, want.len, want.bases, want.holes,
                     want.acc, want.fin);
            $display("  actual   kind=%0d word=%h pos=%0d len=%0d bases=%0d holes=%0d acc=%b fin=%b",
                     got.kind, got.word, got.pos, got.len, got.bases, got.holes,
                     got.acc, got.fin);
        end
    endtask

    // Receiver: random stalls, calm stretches, and a long hold-off on request.
    always @(posedge i_clk) begin
        if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            rx_wait      = LONG_HOLD;
            i_out_ready <= 1'b0;
        end else if (rx_wait != 0) begin
            rx_wait      = rx_wait - 1;
            i_out_ready <= 1'b0;
        end else begin
            rx_gap = calm_phase ? 0 : pick_gap();
            if (rx_gap != 0) begin
                rx_wait      = rx_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Compare every accepted result with the oldest one due.
    always @(posedge i_clk) begin
        nuc_rec_t got;
        nuc_rec_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{t_kind'(o_record_kind), o_packed_word, o_hole_position, o_hole_length,
                    o_base_total, o_hole_total, o_accepted, o_final_record};
            if (due_records.size() == 0) begin
                note_mismatch("result with none due", '0, got);
            end else begin
                want = due_records.pop_front();
                if (got.kind !== want.kind || got.word !== want.word ||
                    got.pos !== want.pos || got.len !== want.len ||
                    got.bases !== want.bases || got.holes !== want.holes ||
                    got.acc !== want.acc || got.fin !== want.fin)
                    note_mismatch("wrong result", want, got);
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("nucleotide_2bit_packer_with_holes: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned rand_items;
        int unsigned seq_no;
        int unsigned style;
        int unsigned seq_len;
        int unsigned hole_left;
        logic [7:0]  ch;
        rand_items = 0;
        seq_no     = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r])
            send_char(dir_rows[r].ch, dir_rows[r].eos, dir_rows[r].typed, dir_rows[r].want);

        // Pause the sender until everything so far has come back.
        drain_results();

        // Random sequences: mostly well formed (first character a base, holes
        // in short runs), some refused by a leading hole, some pure noise.
        while (rand_items < RAND_ITEMS) begin
            calm_phase = ($urandom_range(0, 4) == 0);
            // Hold the receiver off while the sender keeps offering.
            if (seq_no == 2) hold_requests++;
            if (seq_no == 6) drain_results();
            style     = $urandom_range(0, 9);
            seq_len   = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 70)
                                                    : $urandom_range(1, 24);
            // Cut the last sequence short to keep the item total.
            if (seq_len > RAND_ITEMS - rand_items) seq_len = RAND_ITEMS - rand_items;
            hole_left = 0;
            for (int unsigned pos = 0; pos < seq_len; pos++) begin
                if (style == 0) begin
                    ch = 8'($urandom_range(0, 255));
                end else if (pos == 0) begin
                    ch = (style == 1) ? hole_byte() : nuc_letters[$urandom_range(0, 7)];
                end else if (hole_left != 0) begin
                    ch = hole_byte();
                    hole_left--;
                end else if ($urandom_range(0, 4) == 0) begin
                    ch = hole_byte();
                    hole_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
                end else begin
                    ch = nuc_letters[$urandom_range(0, 7)];
                end
                send_char(ch, pos == seq_len - 1, 1'b0, '0);
                rand_items++;
            end
            seq_no++;
        end

        calm_phase = 1'b0;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("nucleotide_2bit_packer_with_holes: match");
        end else begin
            $display("nucleotide_2bit_packer_with_holes: mismatch");
        end
        $finish;
    end

endmodule
